### rtl/gmb_pkg.sv
package gmb_pkg;

  localparam int WeightW = 16;
  localparam int MeanW = 8;
  localparam int DevW = 16;
  localparam int EntryW = WeightW + MeanW + DevW;

  localparam int AluOpW = 32;
  localparam int AluResW = 49;
  localparam int DivRemW = 20;

  localparam logic [4:0] MulLast = 5'd16;
  localparam logic [4:0] DivLast = 5'd31;
  localparam logic [4:0] SqrtLast = 5'd15;
  localparam logic [31:0] SqrtBit0 = 32'h4000_0000;

  localparam logic [15:0] WeightMax = 16'hFFFF;
  localparam logic [15:0] NewWeight = 16'd3277;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [7:0] MaskFg = 8'd255;
  localparam logic [7:0] MaskBg = 8'd0;

  localparam logic [15:0] LrReset = 16'd3277;
  localparam logic [15:0] ThrReset = 16'd45875;
  localparam logic [3:0] MfReset = 4'd3;
  localparam logic [15:0] IdevReset = 16'd3840;

  localparam logic [1:0] ActInit = 2'd0;
  localparam logic [1:0] ActTrain = 2'd1;
  localparam logic [1:0] ActClassify = 2'd2;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_BG_THRESHOLD = 2'd1,
    CFG_MATCH_FACTOR = 2'd2,
    CFG_INIT_DEV = 2'd3
  } gmb_cfg_e;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_SQRT = 2'd2
  } gmb_alu_op_e;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_WRITE, S_OUT,
    S_C_SUM, S_C_MATCH,
    S_T_MATCH, S_T_DEC_GO, S_T_DEC_WT, S_T_W_GO, S_T_W_WT,
    S_T_P_GO, S_T_P_WT, S_T_M1_GO, S_T_M1_WT, S_T_M2_GO, S_T_M2_WT,
    S_T_V0_GO, S_T_V0_WT, S_T_V1_GO, S_T_V1_WT, S_T_V2_GO, S_T_V2_WT,
    S_T_V3_GO, S_T_V3_WT, S_T_SQ_GO, S_T_SQ_WT, S_T_NEXT,
    S_T_NEW, S_T_SUM, S_T_N_GO, S_T_N_WT,
    S_O_LOAD, S_O_A_GO, S_O_A_WT, S_O_B_GO, S_O_B_WT, S_O_STORE
  } gmb_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] pixel_index;
    logic [7:0] pixel_value;
  } gmb_in_t;

  typedef struct packed {
    logic [15:0] out_index;
    logic [7:0] mask_value;
    logic [2:0] background_count;
  } gmb_out_t;

  typedef struct packed {
    logic start;
    gmb_alu_op_e op;
    logic [AluOpW-1:0] a;
    logic [AluOpW-1:0] b;
  } gmb_alu_req_t;

  typedef struct packed {
    logic done;
    logic [AluResW-1:0] res;
  } gmb_alu_rsp_t;

endpackage

### rtl/gaussian_mixture_background_model.sv
// Per-pixel Gaussian mixture background model. Each pixel's COMPONENTS
// Gaussians live as one row of an on-chip RAM; a train reads the row, works
// on it in registers and writes it back, a classify only reads it, and one
// request is handled at a time. Initialize writes the row without reading it.
// A classify waits while the output register still holds an untaken result.
// All arithmetic goes through one shared sequential unit, and a train uses one
// multiply per unmatched component, seven multiplies, a divide (unless the new
// weight is zero) and a root per matched component, one divide per component
// to renormalize (unless the weights sum to zero) and two multiplies for each
// pair compared while sorting. That unit sets the rate. The RAM needs no
// clearing after reset: a pixel must be initialized before it is trained or
// classified. Requests with action 3 or an index of PIXELS or above are
// dropped. Configuration is to be written by the user only while the block
// is idle; the block itself does not enforce it.
module gaussian_mixture_background_model #(
  parameter int COMPONENTS = 5,
  parameter int PIXELS = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gmb_pkg::gmb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gmb_pkg::gmb_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int K = COMPONENTS;
  localparam int KW = $clog2(K);
  localparam int CW = $clog2(K + 1);
  localparam int SW = 16 + $clog2(K);
  localparam int AW = PIXELS > 1 ? $clog2(PIXELS) : 1;
  localparam int RW = K * gmb_pkg::EntryW;

  gmb_pkg::gmb_state_e state_q, state_d;
  logic [15:0] lr_q, thr_q, idev_q;
  logic [3:0] mf_q;
  logic is_cls_q, found_q, fg_q;
  logic [15:0] idx_q;
  logic [7:0] x_q;
  logic [15:0] w_q [K];
  logic [7:0] mu_q [K];
  logic [15:0] dv_q [K];
  logic [15:0] cur_w_q, cur_dv_q;
  logic [7:0] cur_mu_q;
  logic [KW-1:0] k_q, m_q;
  logic [SW-1:0] sum_q;
  logic [CW-1:0] count_q;
  logic [16:0] p_q;
  logic [gmb_pkg::AluResW-1:0] acc_q;
  logic [31:0] tmp_q, lhs_q;
  logic out_valid_q, out_valid_d;
  gmb_pkg::gmb_out_t out_q;

  logic in_acc, in_range, k_last, m_last, out_free;
  logic [15:0] init_dev, wk, dvk, nw, q16, sq_d;
  logic [7:0] muk, off;
  logic [19:0] lim, off20;
  logic is_match, is_inside;
  logic [gmb_pkg::AluResW-1:0] w_sum, acc_sum;
  logic [SW-1:0] sum_n;
  logic [16:0] p_new;
  logic [RW-1:0] row_w, row_r;
  logic ram_re;

  gmb_pkg::gmb_alu_req_t alu_req;
  gmb_pkg::gmb_alu_rsp_t alu_rsp;

  gmb_ram #(.WIDTH(RW), .DEPTH(PIXELS)) u_ram (
    .clk_i(clk_i),
    .we_i(state_q == gmb_pkg::S_WRITE),
    .waddr_i(AW'(idx_q)),
    .wdata_i(row_w),
    .re_i(ram_re),
    .raddr_i(AW'(in_data_i.pixel_index)),
    .rdata_o(row_r)
  );

  gmb_alu u_alu (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  always_comb begin
    in_acc = in_valid_i && !in_stall_o;
    in_range = 32'(in_data_i.pixel_index) < 32'(PIXELS);
    ram_re = in_acc && in_range && (in_data_i.action == gmb_pkg::ActTrain ||
             in_data_i.action == gmb_pkg::ActClassify);
    k_last = k_q == KW'(K - 1);
    m_last = m_q == KW'(K - 2);
    out_free = !out_valid_q || !out_stall_i;
    init_dev = (idev_q == 16'd0) ? 16'd1 : idev_q;
    wk = w_q[k_q];
    muk = mu_q[k_q];
    dvk = dv_q[k_q];
    off = (x_q > muk) ? x_q - muk : muk - x_q;
    off20 = {4'd0, off, 8'd0};
    lim = {16'd0, mf_q} * {4'd0, dvk};
    is_match = off20 <= lim;
    is_inside = off20 < lim;
    w_sum = alu_rsp.res + gmb_pkg::AluResW'({lr_q, 16'd0});
    nw = (|w_sum[gmb_pkg::AluResW-1:32]) ? gmb_pkg::WeightMax : w_sum[31:16];
    acc_sum = acc_q + alu_rsp.res;
    sum_n = sum_q + SW'(wk);
    q16 = (|alu_rsp.res[31:16]) ? gmb_pkg::WeightMax : alu_rsp.res[15:0];
    p_new = (alu_rsp.res[31:0] > 32'(gmb_pkg::OneQ16)) ? gmb_pkg::OneQ16 :
            alu_rsp.res[16:0];
    sq_d = (alu_rsp.res[15:0] == 16'd0) ? 16'd1 : alu_rsp.res[15:0];
    for (int j = 0; j < K; j++) begin
      row_w[j*gmb_pkg::EntryW +: gmb_pkg::EntryW] = {w_q[j], mu_q[j], dv_q[j]};
    end
  end

  // Operand selection for the shared arithmetic unit; operands come from the entry
  // at the current component pointer, the held sort entry, the configuration or registers.
  always_comb begin
    alu_req.start = 1'b1;
    alu_req.op = gmb_pkg::ALU_MUL;
    alu_req.a = 32'(wk);
    alu_req.b = 32'(gmb_pkg::OneQ16 - {1'b0, lr_q});
    case (state_q)
      gmb_pkg::S_T_DEC_GO, gmb_pkg::S_T_W_GO: ;
      gmb_pkg::S_T_P_GO: begin
        alu_req.op = gmb_pkg::ALU_DIV;
        alu_req.a = {lr_q, 16'd0};
        alu_req.b = 32'(wk);
      end
      gmb_pkg::S_T_M1_GO: begin
        alu_req.a = 32'(muk);
        alu_req.b = 32'(gmb_pkg::OneQ16 - p_q);
      end
      gmb_pkg::S_T_M2_GO: begin
        alu_req.a = 32'(x_q);
        alu_req.b = 32'(p_q);
      end
      gmb_pkg::S_T_V0_GO: begin
        alu_req.a = 32'(dvk);
        alu_req.b = 32'(dvk);
      end
      gmb_pkg::S_T_V1_GO: begin
        alu_req.a = tmp_q;
        alu_req.b = 32'(gmb_pkg::OneQ16 - p_q);
      end
      gmb_pkg::S_T_V2_GO: begin
        alu_req.a = 32'({off, 8'd0});
        alu_req.b = 32'({off, 8'd0});
      end
      gmb_pkg::S_T_V3_GO: begin
        alu_req.a = tmp_q;
        alu_req.b = 32'(p_q);
      end
      gmb_pkg::S_T_SQ_GO: begin
        alu_req.op = gmb_pkg::ALU_SQRT;
        alu_req.a = tmp_q;
      end
      gmb_pkg::S_T_N_GO: begin
        alu_req.op = gmb_pkg::ALU_DIV;
        alu_req.a = {wk, 16'd0};
        alu_req.b = 32'(sum_q);
      end
      gmb_pkg::S_O_A_GO: begin
        alu_req.a = 32'(cur_w_q);
        alu_req.b = 32'(dvk);
      end
      gmb_pkg::S_O_B_GO: begin
        alu_req.a = 32'(wk);
        alu_req.b = 32'(cur_dv_q);
      end
      default: alu_req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    in_stall_o = state_q != gmb_pkg::S_IDLE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      gmb_pkg::S_IDLE: begin
        if (in_acc && in_range) begin
          if (in_data_i.action == gmb_pkg::ActInit) begin
            state_d = gmb_pkg::S_WRITE;
          end else if (ram_re) begin
            state_d = gmb_pkg::S_LOAD;
          end
        end
      end
      gmb_pkg::S_LOAD: state_d = is_cls_q ? gmb_pkg::S_C_SUM : gmb_pkg::S_T_MATCH;
      gmb_pkg::S_WRITE: state_d = gmb_pkg::S_IDLE;
      gmb_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d = gmb_pkg::S_IDLE;
        end
      end
      gmb_pkg::S_C_SUM: begin
        if (sum_n >= SW'(thr_q)) begin
          state_d = gmb_pkg::S_C_MATCH;
        end else if (k_last) begin
          state_d = gmb_pkg::S_OUT;
        end
      end
      gmb_pkg::S_C_MATCH: begin
        if (is_inside || k_q == KW'(count_q - CW'(1))) begin
          state_d = gmb_pkg::S_OUT;
        end
      end
      gmb_pkg::S_T_MATCH: state_d = is_match ? gmb_pkg::S_T_W_GO : gmb_pkg::S_T_DEC_GO;
      gmb_pkg::S_T_DEC_GO: state_d = gmb_pkg::S_T_DEC_WT;
      gmb_pkg::S_T_DEC_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_NEXT;
      gmb_pkg::S_T_W_GO: state_d = gmb_pkg::S_T_W_WT;
      gmb_pkg::S_T_W_WT: begin
        if (alu_rsp.done) begin
          state_d = (nw == 16'd0) ? gmb_pkg::S_T_M1_GO : gmb_pkg::S_T_P_GO;
        end
      end
      gmb_pkg::S_T_P_GO: state_d = gmb_pkg::S_T_P_WT;
      gmb_pkg::S_T_P_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_M1_GO;
      gmb_pkg::S_T_M1_GO: state_d = gmb_pkg::S_T_M1_WT;
      gmb_pkg::S_T_M1_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_M2_GO;
      gmb_pkg::S_T_M2_GO: state_d = gmb_pkg::S_T_M2_WT;
      gmb_pkg::S_T_M2_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_V0_GO;
      gmb_pkg::S_T_V0_GO: state_d = gmb_pkg::S_T_V0_WT;
      gmb_pkg::S_T_V0_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_V1_GO;
      gmb_pkg::S_T_V1_GO: state_d = gmb_pkg::S_T_V1_WT;
      gmb_pkg::S_T_V1_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_V2_GO;
      gmb_pkg::S_T_V2_GO: state_d = gmb_pkg::S_T_V2_WT;
      gmb_pkg::S_T_V2_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_V3_GO;
      gmb_pkg::S_T_V3_GO: state_d = gmb_pkg::S_T_V3_WT;
      gmb_pkg::S_T_V3_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_SQ_GO;
      gmb_pkg::S_T_SQ_GO: state_d = gmb_pkg::S_T_SQ_WT;
      gmb_pkg::S_T_SQ_WT: if (alu_rsp.done) state_d = gmb_pkg::S_T_NEXT;
      gmb_pkg::S_T_NEXT: begin
        if (!k_last) begin
          state_d = gmb_pkg::S_T_MATCH;
        end else begin
          state_d = found_q ? gmb_pkg::S_T_SUM : gmb_pkg::S_T_NEW;
        end
      end
      gmb_pkg::S_T_NEW: if (wk == 16'd0 || k_last) state_d = gmb_pkg::S_T_SUM;
      gmb_pkg::S_T_SUM: begin
        if (k_last) begin
          state_d = (sum_n == '0) ? gmb_pkg::S_O_LOAD : gmb_pkg::S_T_N_GO;
        end
      end
      gmb_pkg::S_T_N_GO: state_d = gmb_pkg::S_T_N_WT;
      gmb_pkg::S_T_N_WT: begin
        if (alu_rsp.done) begin
          state_d = k_last ? gmb_pkg::S_O_LOAD : gmb_pkg::S_T_N_GO;
        end
      end
      gmb_pkg::S_O_LOAD: state_d = gmb_pkg::S_O_A_GO;
      gmb_pkg::S_O_A_GO: state_d = gmb_pkg::S_O_A_WT;
      gmb_pkg::S_O_A_WT: if (alu_rsp.done) state_d = gmb_pkg::S_O_B_GO;
      gmb_pkg::S_O_B_GO: state_d = gmb_pkg::S_O_B_WT;
      gmb_pkg::S_O_B_WT: begin
        if (alu_rsp.done) begin
          state_d = k_last ? gmb_pkg::S_O_STORE : gmb_pkg::S_O_A_GO;
        end
      end
      gmb_pkg::S_O_STORE: state_d = m_last ? gmb_pkg::S_WRITE : gmb_pkg::S_O_LOAD;
      default: state_d = gmb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmb_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      lr_q <= gmb_pkg::LrReset;
      thr_q <= gmb_pkg::ThrReset;
      mf_q <= gmb_pkg::MfReset;
      idev_q <= gmb_pkg::IdevReset;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          gmb_pkg::CFG_LEARNING_RATE: lr_q <= cfg_wdata_i;
          gmb_pkg::CFG_BG_THRESHOLD: thr_q <= cfg_wdata_i;
          gmb_pkg::CFG_MATCH_FACTOR: mf_q <= cfg_wdata_i[3:0];
          gmb_pkg::CFG_INIT_DEV: idev_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Working copy of one pixel's components. Sorting keeps the entry at the
  // outer position in the cur registers and swaps it with each later entry whose weight-to-deviation ratio is higher.
  always_ff @(posedge clk_i) begin
    case (state_q)
      gmb_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_q <= in_data_i.pixel_index;
          x_q <= in_data_i.pixel_value;
          is_cls_q <= in_data_i.action == gmb_pkg::ActClassify;
          for (int j = 0; j < K; j++) begin
            w_q[j] <= (j == 0) ? gmb_pkg::WeightMax : 16'd0;
            mu_q[j] <= (j == 0) ? in_data_i.pixel_value : 8'd0;
            dv_q[j] <= init_dev;
          end
        end
      end
      gmb_pkg::S_LOAD: begin
        for (int j = 0; j < K; j++) begin
          {w_q[j], mu_q[j], dv_q[j]} <= row_r[j*gmb_pkg::EntryW +: gmb_pkg::EntryW];
        end
        k_q <= '0;
        found_q <= 1'b0;
        sum_q <= '0;
        fg_q <= 1'b1;
        count_q <= '0;
      end
      gmb_pkg::S_OUT: begin
        if (out_free) begin
          out_q.out_index <= idx_q;
          out_q.mask_value <= fg_q ? gmb_pkg::MaskFg : gmb_pkg::MaskBg;
          out_q.background_count <= 3'(count_q);
        end
      end
      gmb_pkg::S_C_SUM: begin
        sum_q <= sum_n;
        if (sum_n >= SW'(thr_q)) begin
          count_q <= CW'(k_q) + CW'(1);
          k_q <= '0;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
      gmb_pkg::S_C_MATCH: begin
        if (is_inside) begin
          fg_q <= 1'b0;
        end
        k_q <= k_q + KW'(1);
      end
      gmb_pkg::S_T_MATCH: if (is_match) found_q <= 1'b1;
      gmb_pkg::S_T_DEC_WT: if (alu_rsp.done) w_q[k_q] <= alu_rsp.res[31:16];
      gmb_pkg::S_T_W_WT: begin
        if (alu_rsp.done) begin
          w_q[k_q] <= nw;
          p_q <= '0;
        end
      end
      gmb_pkg::S_T_P_WT: if (alu_rsp.done) p_q <= p_new;
      gmb_pkg::S_T_M1_WT, gmb_pkg::S_T_V1_WT: if (alu_rsp.done) acc_q <= alu_rsp.res;
      gmb_pkg::S_T_M2_WT: if (alu_rsp.done) mu_q[k_q] <= acc_sum[23:16];
      gmb_pkg::S_T_V0_WT, gmb_pkg::S_T_V2_WT: if (alu_rsp.done) tmp_q <= alu_rsp.res[31:0];
      gmb_pkg::S_T_V3_WT: if (alu_rsp.done) tmp_q <= acc_sum[47:16];
      gmb_pkg::S_T_SQ_WT: if (alu_rsp.done) dv_q[k_q] <= sq_d;
      gmb_pkg::S_T_NEXT: k_q <= k_last ? '0 : k_q + KW'(1);
      gmb_pkg::S_T_NEW: begin
        if (wk == 16'd0 || k_last) begin
          mu_q[k_q] <= x_q;
          dv_q[k_q] <= init_dev;
          w_q[k_q] <= gmb_pkg::NewWeight;
          k_q <= '0;
          sum_q <= '0;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
      gmb_pkg::S_T_SUM: begin
        sum_q <= sum_n;
        k_q <= k_last ? '0 : k_q + KW'(1);
        m_q <= '0;
      end
      gmb_pkg::S_T_N_WT: begin
        if (alu_rsp.done) begin
          w_q[k_q] <= q16;
          k_q <= k_last ? '0 : k_q + KW'(1);
          m_q <= '0;
        end
      end
      gmb_pkg::S_O_LOAD: begin
        cur_w_q <= wk;
        cur_mu_q <= muk;
        cur_dv_q <= dvk;
        k_q <= k_q + KW'(1);
      end
      gmb_pkg::S_O_A_WT: if (alu_rsp.done) lhs_q <= alu_rsp.res[31:0];
      gmb_pkg::S_O_B_WT: begin
        if (alu_rsp.done) begin
          if (lhs_q < alu_rsp.res[31:0]) begin
            w_q[k_q] <= cur_w_q;
            mu_q[k_q] <= cur_mu_q;
            dv_q[k_q] <= cur_dv_q;
            cur_w_q <= wk;
            cur_mu_q <= muk;
            cur_dv_q <= dvk;
          end
          if (!k_last) begin
            k_q <= k_q + KW'(1);
          end
        end
      end
      gmb_pkg::S_O_STORE: begin
        w_q[m_q] <= cur_w_q;
        mu_q[m_q] <= cur_mu_q;
        dv_q[m_q] <= cur_dv_q;
        m_q <= m_q + KW'(1);
        k_q <= m_q + KW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

### rtl/gmb_ram.sv
module gmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gmb_alu.sv
module gmb_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gmb_pkg::gmb_alu_req_t req_i,
  output gmb_pkg::gmb_alu_rsp_t rsp_o
);

  logic busy_q, done_q;
  gmb_pkg::gmb_alu_op_e op_q;
  logic [4:0] cnt_q;
  logic [31:0] a_q, b_q, rt_q, bt_q;
  logic [gmb_pkg::AluResW-1:0] acc_q;
  logic [gmb_pkg::DivRemW-1:0] rem_q;

  logic [gmb_pkg::AluResW-1:0] mul_acc;
  logic [gmb_pkg::DivRemW:0] rem_sh, rem_n;
  logic div_ge;
  logic [31:0] sq_t, rt_n;
  logic sq_ge, last;

  // Multiply walks the 17-bit multiplier from its top bit; divide is restoring;
  // the root takes two radicand bits a step.
  always_comb begin
    mul_acc = {acc_q[gmb_pkg::AluResW-2:0], 1'b0} +
              (b_q[16] ? gmb_pkg::AluResW'(a_q) : '0);
    rem_sh = {rem_q, a_q[31]};
    div_ge = rem_sh >= b_q[gmb_pkg::DivRemW:0];
    rem_n = div_ge ? rem_sh - b_q[gmb_pkg::DivRemW:0] : rem_sh;
    sq_t = rt_q + bt_q;
    sq_ge = a_q >= sq_t;
    rt_n = sq_ge ? (rt_q >> 1) + bt_q : rt_q >> 1;
    case (op_q)
      gmb_pkg::ALU_MUL: last = cnt_q == gmb_pkg::MulLast;
      gmb_pkg::ALU_DIV: last = cnt_q == gmb_pkg::DivLast;
      gmb_pkg::ALU_SQRT: last = cnt_q == gmb_pkg::SqrtLast;
      default: last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      cnt_q <= '0;
      a_q <= req_i.a;
      b_q <= req_i.b;
      acc_q <= '0;
      rem_q <= '0;
      rt_q <= '0;
      bt_q <= gmb_pkg::SqrtBit0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      case (op_q)
        gmb_pkg::ALU_MUL: begin
          acc_q <= mul_acc;
          b_q <= b_q << 1;
        end
        gmb_pkg::ALU_DIV: begin
          rem_q <= rem_n[gmb_pkg::DivRemW-1:0];
          a_q <= a_q << 1;
          acc_q <= {acc_q[gmb_pkg::AluResW-2:0], div_ge};
        end
        gmb_pkg::ALU_SQRT: begin
          if (sq_ge) begin
            a_q <= a_q - sq_t;
          end
          rt_q <= rt_n;
          bt_q <= bt_q >> 2;
          acc_q <= gmb_pkg::AluResW'(rt_n);
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res = acc_q;

endmodule

### rtl/gmb_checker.sv
module gmb_checker #(
  parameter int PIXELS = 65536
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input gmb_pkg::gmb_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gmb_pkg::gmb_out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed or dropped");

  // Requests are taken only when no earlier one is in flight, so no result
  // can appear right after an accepted request.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a request");

  // A classify request in range keeps the block busy for the next cycle.
  a_cls_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.action == gmb_pkg::ActClassify &&
    32'(in_data_i.pixel_index) < 32'(PIXELS) |=> in_stall_o)
    else $error("classify request did not occupy the block");

  // Without background components the pixel is always foreground.
  a_empty_is_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.background_count == 3'd0 |->
    out_data_o.mask_value == gmb_pkg::MaskFg)
    else $error("background pixel reported with no background components");

endmodule

bind gaussian_mixture_background_model gmb_checker #(.PIXELS(PIXELS)) u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .in_data_i(in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o(out_data_o)
);

### dv/tb_gaussian_mixture_background_model.sv
`timescale 1ns / 1ps

module tb_gaussian_mixture_background_model;
  import gmb_pkg::*;

  localparam int NumComp = 5;
  localparam int PoolSize = 20;
  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 3000;

  typedef logic [15:0] wrow_t[NumComp];
  typedef logic [7:0] mrow_t[NumComp];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gmb_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gmb_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  // Shadow of the configuration registers and of the pixel models.
  logic [15:0] alpha_q16 = LrReset;
  logic [15:0] bg_thresh = ThrReset;
  logic [3:0] match_dev = MfReset;
  logic [15:0] new_dev = IdevReset;
  wrow_t weight_mem[int];
  mrow_t mean_mem[int];
  wrow_t dev_mem[int];

  gmb_out_t mask_q[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold = 1'b0;
  int idle_cnt = 0;

  int unsigned pool_idx[PoolSize];
  logic [7:0] pool_base[PoolSize];
  bit pool_live[PoolSize];

  gaussian_mixture_background_model u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] seed_dev();
    return (new_dev == 0) ? 16'd1 : new_dev;
  endfunction

  function automatic void update_pixel(int unsigned idx, longint unsigned x);
    wrow_t w;
    mrow_t mu;
    wrow_t dv;
    longint unsigned a, off, nw, p, var_q, d, total, q;
    logic [15:0] t16;
    logic [7:0] t8;
    int k;
    bit hit;
    w = weight_mem[idx];
    mu = mean_mem[idx];
    dv = dev_mem[idx];
    a = alpha_q16;
    hit = 1'b0;
    total = 0;
    for (k = 0; k < NumComp; k++) begin
      off = abs_diff(x, mu[k]);
      if (off * 256 <= longint'(match_dev) * dv[k]) begin
        nw = ((65536 - a) * w[k] + a * 65536) >> 16;
        if (nw > 65535) nw = 65535;
        w[k] = nw[15:0];
        p = (nw != 0) ? (a << 16) / nw : 0;
        if (p > 65536) p = 65536;
        mu[k] = 8'(((65536 - p) * mu[k] + p * x) >> 16);
        off = abs_diff(x, mu[k]) * 256;
        var_q = ((65536 - p) * (longint'(dv[k]) * dv[k]) + p * off * off) >> 16;
        d = int_sqrt(var_q);
        if (d < 1) d = 1;
        if (d > 65535) d = 65535;
        dv[k] = d[15:0];
        hit = 1'b1;
      end else begin
        w[k] = 16'(((65536 - a) * w[k]) >> 16);
      end
    end
    if (!hit) begin
      for (k = 0; k < NumComp - 1; k++)
        if (w[k] == 0) break;
      mu[k] = x[7:0];
      dv[k] = seed_dev();
      w[k] = NewWeight;
    end
    for (k = 0; k < NumComp; k++) total += w[k];
    if (total != 0) begin
      for (k = 0; k < NumComp; k++) begin
        q = (longint'(w[k]) << 16) / total;
        w[k] = (q > 65535) ? 16'hFFFF : q[15:0];
      end
    end
    for (int m = 0; m < NumComp; m++) begin
      for (int n = m + 1; n < NumComp; n++) begin
        if (longint'(w[m]) * dv[n] < longint'(w[n]) * dv[m]) begin
          t16 = w[m]; w[m] = w[n]; w[n] = t16;
          t16 = dv[m]; dv[m] = dv[n]; dv[n] = t16;
          t8 = mu[m]; mu[m] = mu[n]; mu[n] = t8;
        end
      end
    end
    weight_mem[idx] = w;
    mean_mem[idx] = mu;
    dev_mem[idx] = dv;
  endfunction

  // Applies one accepted request to the shadow models; classify queues its mask.
  function automatic void predict_request(gmb_in_t r);
    wrow_t w;
    mrow_t mu;
    wrow_t dv;
    gmb_out_t res;
    longint unsigned sum;
    int cnt;
    int unsigned idx;
    idx = r.pixel_index;
    case (r.action)
      ActInit: begin
        for (int k = 0; k < NumComp; k++) begin
          w[k] = '0;
          mu[k] = '0;
          dv[k] = seed_dev();
        end
        w[0] = WeightMax;
        mu[0] = r.pixel_value;
        weight_mem[idx] = w;
        mean_mem[idx] = mu;
        dev_mem[idx] = dv;
      end
      ActTrain: update_pixel(idx, r.pixel_value);
      ActClassify: begin
        w = weight_mem[idx];
        mu = mean_mem[idx];
        dv = dev_mem[idx];
        sum = 0;
        cnt = 0;
        for (int k = 0; k < NumComp; k++) begin
          sum += w[k];
          if (sum >= bg_thresh) begin
            cnt = k + 1;
            break;
          end
        end
        res.out_index = r.pixel_index;
        res.mask_value = MaskFg;
        res.background_count = 3'(cnt);
        for (int k = 0; k < cnt; k++) begin
          if (abs_diff(r.pixel_value, mu[k]) * 256 < longint'(match_dev) * dv[k]) begin
            res.mask_value = MaskBg;
            break;
          end
        end
        mask_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(logic [1:0] act, logic [15:0] idx, logic [7:0] val);
    gmb_in_t r;
    r.action = act;
    r.pixel_index = idx;
    r.pixel_value = val;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (mask_q.size() != 0) @(posedge clk_i);
    // A train that yields no result may still be running.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(gmb_cfg_e idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE: alpha_q16 = data;
      CFG_BG_THRESHOLD: bg_thresh = data;
      CFG_MATCH_FACTOR: match_dev = data[3:0];
      default: new_dev = data;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(ActInit, 16'h0000, 8'h00);
    send_req(ActInit, 16'hFFFF, 8'hFF);
    send_req(ActClassify, 16'h0000, 8'h00);
    send_req(ActClassify, 16'hFFFF, 8'h00);
    send_req(ActClassify, 16'hFFFF, 8'hF0);
    send_req(ActTrain, 16'h0000, 8'h05);
    send_req(ActTrain, 16'h0000, 8'hFF);
    send_req(ActTrain, 16'h0000, 8'h80);
    send_req(ActTrain, 16'hFFFF, 8'hFF);
    send_req(ActClassify, 16'h0000, 8'h80);
    send_req(ActClassify, 16'h0000, 8'h40);
    send_req(2'd3, 16'h5555, 8'hAA);
    send_req(2'd3, 16'hAAAA, 8'h55);
    for (int i = 0; i < 5; i++) send_req(ActTrain, 16'h0000, 8'(i * 60));
    send_req(ActClassify, 16'h0000, 8'hB4);
    send_req(ActClassify, 16'hFFFF, 8'hFE);
    drain();
  endtask

  task automatic test_random(int n_items);
    int p, r;
    logic [7:0] val;
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(PoolSize - 1);
      if ($urandom_range(99) < 3) pool_base[p] = 8'($urandom);
      if ($urandom_range(99) < 80) begin
        val = 8'(int'(pool_base[p]) + $urandom_range(16) - 8);
      end else begin
        val = 8'($urandom);
      end
      r = $urandom_range(99);
      if (!pool_live[p] || r < 5) begin
        send_req(ActInit, 16'(pool_idx[p]), val);
        pool_live[p] = 1'b1;
      end else if (r < 10) begin
        send_req(2'd3, 16'($urandom), 8'($urandom));
      end else if (r < 42) begin
        send_req(ActTrain, 16'(pool_idx[p]), val);
      end else begin
        send_req(ActClassify, 16'(pool_idx[p]), val);
      end
    end
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_LEARNING_RATE, 16'hFFFF);
    write_reg(CFG_BG_THRESHOLD, 16'h0000);
    write_reg(CFG_MATCH_FACTOR, 16'd15);
    write_reg(CFG_INIT_DEV, 16'h0000);
    test_random(150);
    write_reg(CFG_LEARNING_RATE, 16'h0000);
    write_reg(CFG_BG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_MATCH_FACTOR, 16'd1);
    write_reg(CFG_INIT_DEV, 16'hFFFF);
    test_random(150);
    write_reg(CFG_LEARNING_RATE, 16'd655);
    write_reg(CFG_BG_THRESHOLD, 16'd32768);
    write_reg(CFG_MATCH_FACTOR, 16'd2);
    write_reg(CFG_INIT_DEV, 16'd1);
    test_random(150);
    write_reg(CFG_LEARNING_RATE, 16'(16'd1 + $urandom_range(20000)));
    write_reg(CFG_BG_THRESHOLD, 16'($urandom));
    write_reg(CFG_MATCH_FACTOR, 16'($urandom_range(15, 1)));
    write_reg(CFG_INIT_DEV, 16'($urandom_range(65535, 1)));
    test_random(150);
  endtask

  // Output held off long enough that the block fills and stalls its input.
  task automatic test_pressure();
    hold_go = 1'b1;
    for (int i = 0; i < 12; i++) send_req(ActClassify, 16'(pool_idx[0]), 8'($urandom));
    hold_go = 1'b0;
    drain();
  endtask

  always begin
    wait (hold_go);
    hold = 1'b1;
    repeat (400) @(posedge clk_i);
    hold = 1'b0;
    wait (!hold_go);
  end

  always @(posedge clk_i) begin
    if (hold) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 31);
    end
  end

  always @(posedge clk_i) begin
    gmb_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mask_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        exp_res = mask_q.pop_front();
        if (out_data_o.out_index !== exp_res.out_index) begin
          $display("%0t: out_index expected %0d actual %0d", $time,
                   exp_res.out_index, out_data_o.out_index);
          errors++;
        end
        if (out_data_o.mask_value !== exp_res.mask_value) begin
          $display("%0t: mask_value expected %0d actual %0d", $time,
                   exp_res.mask_value, out_data_o.mask_value);
          errors++;
        end
        if (out_data_o.background_count !== exp_res.background_count) begin
          $display("%0t: background_count expected %0d actual %0d", $time,
                   exp_res.background_count, out_data_o.background_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt > IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, mask_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PoolSize; i++) begin
      pool_idx[i] = $urandom_range(65535);
      pool_base[i] = 8'($urandom);
      pool_live[i] = 1'b0;
    end
    pool_idx[0] = 0;
    pool_idx[1] = 65535;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    calm = 1'b1;
    test_random(150);
    calm = 1'b0;
    test_pressure();
    test_config_sweep();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/gmb_pkg.sv
rtl/gmb_ram.sv
rtl/gmb_alu.sv
rtl/gaussian_mixture_background_model.sv
rtl/gmb_checker.sv
dv/tb_gaussian_mixture_background_model.sv
